>>> rtl/ptsp_pkg.sv
// ----------------------------------------------------------------------------
// ptsp_pkg: shared types and constants of the TCAM slot planner
// Field widths, command and result codes, and the cell shift control.
// ----------------------------------------------------------------------------
package ptsp_pkg;

  localparam int LENGTHS = 33;   // prefix lengths 0..32, one cell each
  localparam int LEN_W   = 6;
  localparam int SLOT_W  = 12;
  localparam int KIND_W  = 3;

  localparam logic [LEN_W-1:0] LAST_LEN = LEN_W'(LENGTHS - 1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [KIND_W-1:0] KIND_MOVE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PLACE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FREE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MISSING = 3'd4;

  // ring rotation: fwd takes the upper neighbor, bwd the lower one
  typedef struct packed {
    logic fwd;
    logic bwd;
  } shift_ctl_t;

endpackage

>>> rtl/ptsp_if.sv
// ----------------------------------------------------------------------------
// ptsp channels: command and result item channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ptsp_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [ptsp_pkg::LEN_W-1:0]   prefix_length;
  logic [ptsp_pkg::SLOT_W-1:0]  slot_index;

  modport source (output valid, command, prefix_length, slot_index, input ready);
  modport sink   (input valid, command, prefix_length, slot_index, output ready);
endinterface

interface ptsp_out_if;
  logic                         valid;
  logic                         ready;
  logic [ptsp_pkg::KIND_W-1:0]  result_kind;
  logic [ptsp_pkg::SLOT_W-1:0]  source_slot;
  logic [ptsp_pkg::SLOT_W-1:0]  target_slot;
  logic                         last_result;

  modport source (output valid, result_kind, source_slot, target_slot, last_result,
                  input ready);
  modport sink   (input valid, result_kind, source_slot, target_slot, last_result,
                  output ready);
endinterface

>>> rtl/ptsp_cell.sv
// ----------------------------------------------------------------------------
// ptsp_cell: one group counter of the rotating count ring
// Holds one prefix length's route count and shifts it to a neighbor.
// ----------------------------------------------------------------------------
module ptsp_cell #(
  parameter int CW = 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptsp_pkg::shift_ctl_t shift,
  input  logic [CW-1:0]        from_next,
  input  logic [CW-1:0]        from_prev,
  output logic [CW-1:0]        count
);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  always_comb begin
    priority if (shift.fwd) begin
      count_nxt = from_next;
    end else if (shift.bwd) begin
      count_nxt = from_prev;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

>>> rtl/prefix_ordered_tcam_slot_planner_core.sv
// ----------------------------------------------------------------------------
// prefix_ordered_tcam_slot_planner_core: move planner for a length-sorted TCAM
// Lists the entry moves and the final slot for each route insert or remove.
// ----------------------------------------------------------------------------
// The route counts per prefix length sit in a ring of 33 cells that rotates
// one position per cycle while the output register can be loaded; the
// controller sees the count leaving the ring at the wrap point, updates it
// on the way back in, and keeps a running slot sum. An insert holds the
// block for the accept plus a forward walk over lengths 0..32. A remove
// holds it for the accept plus a backward walk over lengths 32..0, and
// then the free-slot item when the route is found. Commands answered at
// once (table full, length above 32) are answered from idle without a walk.
// Each walk ends with the ring back in its home position. Result items go
// out through a single output register; while it is held by the sink the
// walk pauses. One command is in work at a time: in_ch.ready is high only
// between commands and when the output register can be loaded. Slot
// outputs are the low 12 bits of the slot numbers.
module prefix_ordered_tcam_slot_planner_core #(
  parameter int TABLE_SLOTS = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  ptsp_in_if.sink    in_ch,
  ptsp_out_if.source out_ch
);

  // count width holds TABLE_SLOTS itself; AW also covers a 12-bit slot
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int AW = (CW > ptsp_pkg::SLOT_W) ? CW : ptsp_pkg::SLOT_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_REM  = 4'b0100,
    S_FREE = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [ptsp_pkg::LEN_W-1:0]    m_r, m_nxt;         // length being visited
  logic [ptsp_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [ptsp_pkg::SLOT_W-1:0]   slot_r, slot_nxt;
  logic [CW-1:0]                 acc_r, acc_nxt;     // running slot sum
  logic [AW-1:0]                 hole_r, hole_nxt;
  logic                          ok_r, ok_nxt;       // remove passed its check
  logic [CW-1:0]                 entry_count_r, entry_nxt;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [ptsp_pkg::KIND_W-1:0]   out_kind_r;
  logic [ptsp_pkg::SLOT_W-1:0]   out_src_r;
  logic [ptsp_pkg::SLOT_W-1:0]   out_dst_r;
  logic                          out_last_r;

  logic                          can_load;
  logic                          in_accept;
  logic                          emit;
  logic [ptsp_pkg::KIND_W-1:0]   e_kind;
  logic [AW-1:0]                 e_src;
  logic [AW-1:0]                 e_dst;
  logic                          e_last;

  // ring
  ptsp_pkg::shift_ctl_t          shift;
  logic [CW-1:0]                 cnt [ptsp_pkg::LENGTHS];
  logic [CW-1:0]                 wrap_val;
  logic [CW-1:0]                 c_ins, c_rem, t_rem;
  logic [AW-1:0]                 top_ext, slot_ext;
  logic                          ok_now, ok_fin;

  // ---------------------------------------------------------------------------
  // Count ring: cell 0 wraps to cell 32 going forward, and back again.
  // The value crossing the wrap is the one the controller may update.
  // ---------------------------------------------------------------------------
  for (genvar p = 0; p < ptsp_pkg::LENGTHS; p++) begin : g_cell
    logic [CW-1:0] nxt_v, prv_v;
    if (p == ptsp_pkg::LENGTHS - 1) begin : g_top
      assign nxt_v = wrap_val;
    end else begin : g_mid_n
      assign nxt_v = cnt[p+1];
    end
    if (p == 0) begin : g_bot
      assign prv_v = wrap_val;
    end else begin : g_mid_p
      assign prv_v = cnt[p-1];
    end
    ptsp_cell #(.CW(CW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift     (shift),
      .from_next (nxt_v),
      .from_prev (prv_v),
      .count     (cnt[p])
    );
  end

  assign can_load     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) && can_load;
  assign in_accept    = in_ch.valid && in_ch.ready;

  // forward walk reads the head cell, backward walk the tail cell
  assign c_ins    = cnt[0];
  assign c_rem    = cnt[ptsp_pkg::LENGTHS-1];
  assign t_rem    = acc_r + c_rem;                 // first slot past group m
  assign top_ext  = AW'(t_rem) - AW'(1);
  assign slot_ext = AW'(slot_r);
  // acc_r is the base of the group being visited on the backward walk
  assign ok_now   = (c_rem != '0) && (slot_ext >= AW'(acc_r)) && (slot_ext < AW'(t_rem));
  assign ok_fin   = (m_r == len_r) ? ok_now : ok_r;

  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    len_nxt   = len_r;
    slot_nxt  = slot_r;
    acc_nxt   = acc_r;
    hole_nxt  = hole_r;
    ok_nxt    = ok_r;
    entry_nxt = entry_count_r;
    emit      = 1'b0;
    e_kind    = ptsp_pkg::KIND_MOVE;
    e_src     = '0;
    e_dst     = '0;
    e_last    = 1'b0;
    shift     = '0;
    wrap_val  = c_ins;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          len_nxt  = in_ch.prefix_length;
          slot_nxt = in_ch.slot_index;
          priority if (in_ch.prefix_length > ptsp_pkg::LAST_LEN) begin
            emit   = 1'b1;
            e_kind = ptsp_pkg::KIND_MISSING;
            e_last = 1'b1;
          end else if (in_ch.command == ptsp_pkg::CMD_INSERT) begin
            if (entry_count_r >= CW'(TABLE_SLOTS)) begin
              emit   = 1'b1;
              e_kind = ptsp_pkg::KIND_FULL;
              e_last = 1'b1;
            end else begin
              state_nxt = S_INS;
              m_nxt     = '0;
              acc_nxt   = entry_count_r;   // top of group 0 is the table end
            end
          end else begin
            state_nxt = S_REM;
            m_nxt     = ptsp_pkg::LAST_LEN;
            acc_nxt   = '0;
            ok_nxt    = 1'b0;
          end
        end
      end

      // lengths 0 upward: each shorter group rolls its lowest entry to its top, then the route is placed
      S_INS: begin
        if (can_load) begin
          shift.fwd = 1'b1;
          if ((m_r < len_r) && (c_ins != '0)) begin
            emit   = 1'b1;
            e_kind = ptsp_pkg::KIND_MOVE;
            e_src  = AW'(acc_r - c_ins);
            e_dst  = AW'(acc_r);
          end
          if (m_r == len_r) begin
            emit      = 1'b1;
            e_kind    = ptsp_pkg::KIND_PLACE;
            e_dst     = AW'(acc_r);
            e_last    = 1'b1;
            wrap_val  = c_ins + CW'(1);
            entry_nxt = entry_count_r + CW'(1);
          end
          acc_nxt = acc_r - c_ins;
          m_nxt   = m_r + 1'b1;
          if (m_r == ptsp_pkg::LAST_LEN) begin
            state_nxt = S_IDLE;
          end
        end
      end

      // lengths 32 downward: sums up group bases, then chains the hole down
      S_REM: begin
        if (can_load) begin
          shift.bwd = 1'b1;
          wrap_val  = c_rem;
          acc_nxt   = t_rem;
          if (m_r == len_r) begin
            ok_nxt = ok_now;
            if (!ok_now) begin
              emit   = 1'b1;
              e_kind = ptsp_pkg::KIND_MISSING;
              e_last = 1'b1;
            end else begin
              wrap_val = c_rem - CW'(1);
              hole_nxt = top_ext;
              if (top_ext != slot_ext) begin
                emit   = 1'b1;
                e_kind = ptsp_pkg::KIND_MOVE;
                e_src  = top_ext;
                e_dst  = slot_ext;
              end
            end
          end else if ((m_r < len_r) && ok_r && (c_rem != '0)) begin
            hole_nxt = top_ext;
            if (top_ext != hole_r) begin
              emit   = 1'b1;
              e_kind = ptsp_pkg::KIND_MOVE;
              e_src  = top_ext;
              e_dst  = hole_r;
            end
          end
          m_nxt = m_r - 1'b1;
          if (m_r == '0) begin
            state_nxt = ok_fin ? S_FREE : S_IDLE;
          end
        end
      end

      S_FREE: begin
        if (can_load) begin
          emit      = 1'b1;
          e_kind    = ptsp_pkg::KIND_FREE;
          e_dst     = AW'(entry_count_r - CW'(1));
          e_last    = 1'b1;
          entry_nxt = entry_count_r - CW'(1);
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= '0;
      out_valid_r   <= 1'b0;
      ok_r          <= 1'b0;
      m_r           <= '0;
    end else begin
      state_r       <= state_nxt;
      entry_count_r <= entry_nxt;
      out_valid_r   <= out_valid_nxt;
      ok_r          <= ok_nxt;
      m_r           <= m_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    slot_r <= slot_nxt;
    acc_r  <= acc_nxt;
    hole_r <= hole_nxt;
    if (emit) begin
      out_kind_r <= e_kind;
      out_src_r  <= e_src[ptsp_pkg::SLOT_W-1:0];
      out_dst_r  <= e_dst[ptsp_pkg::SLOT_W-1:0];
      out_last_r <= e_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.source_slot = out_src_r;
  assign out_ch.target_slot = out_dst_r;
  assign out_ch.last_result = out_last_r;

`ifndef NO_ASSERTIONS
  // the route total never passes the table size
  a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= CW'(TABLE_SLOTS))
    else $error("entry count above table size");

  // placing a new route bumps the total by exactly one
  a_place_count: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (e_kind == ptsp_pkg::KIND_PLACE)) |=>
      (entry_count_r == $past(entry_count_r) + CW'(1)))
    else $error("place without count update");

  // no new command is taken while a walk is running
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready)
    else $error("command accepted during a walk");

  // a produced item never overwrites one the sink has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_ch.ready))
    else $error("output register overwritten");
`endif

endmodule

>>> tb/prefix_ordered_tcam_slot_planner_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prefix_ordered_tcam_slot_planner_core_tb: self-checking bench for the planner
// Drives insert/remove commands, mirrors the per-length route counts, predicts
// every move/place/free item and checks the result stream field by field.
// ----------------------------------------------------------------------------
module prefix_ordered_tcam_slot_planner_core_tb;

  localparam int TABLE_SLOTS = 4096;
  localparam int STALL_LIMIT = 5000;  // cycles with no item moved on either side
  localparam int LONG_HOLD   = 400;   // long receiver hold-off, in cycles
  localparam int TAIL_CYCLES = 50;    // about one walk plus margin
  localparam int MAX_REPORTS = 20;

  // one result item as the host would see it
  typedef struct packed {
    logic [ptsp_pkg::KIND_W-1:0] kind;
    logic [ptsp_pkg::SLOT_W-1:0] src;
    logic [ptsp_pkg::SLOT_W-1:0] dst;
    logic                        last;
  } plan_item_t;

  logic clk;
  logic rst_n;

  ptsp_in_if  in_ch ();
  ptsp_out_if out_ch ();

  prefix_ordered_tcam_slot_planner_core #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // mirror of the table occupancy: routes per prefix length and in total
  int route_cnt [ptsp_pkg::LENGTHS];
  int route_total;

  // moves and closing items still owed by the block, oldest first
  plan_item_t planned_q[$];

  int snd_idle_pct;
  int rcv_stall_pct;
  int long_hold_req;

  int err_cnt;
  int reports;
  int results_checked;
  int n_inserts, n_removes, n_missing, n_full, moves_planned;
  int peak_total;

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // first slot of a length group: all routes with a longer prefix sit below it
  function automatic int group_first(int len);
    int s;
    s = 0;
    for (int k = len + 1; k < ptsp_pkg::LENGTHS; k++) s += route_cnt[k];
    return s;
  endfunction

  // length group that owns a slot, -1 past the end of the table
  function automatic int length_of_slot(int slot);
    int acc;
    acc = 0;
    for (int l = ptsp_pkg::LENGTHS - 1; l >= 0; l--) begin
      if (slot < acc + route_cnt[l]) return l;
      acc += route_cnt[l];
    end
    return -1;
  endfunction

  function automatic void add_plan(logic [ptsp_pkg::KIND_W-1:0] kind, int src, int dst,
                                   logic last);
    plan_item_t p;
    p.kind = kind;
    p.src  = ptsp_pkg::SLOT_W'(src);   // slots wider than the port are cut to the low bits
    p.dst  = ptsp_pkg::SLOT_W'(dst);
    p.last = last;
    planned_q.push_back(p);
    if (kind == ptsp_pkg::KIND_MOVE) moves_planned++;
  endfunction

  // Works out the items one accepted command causes and updates the mirror.
  function automatic void plan_command(logic cmd, logic [ptsp_pkg::LEN_W-1:0] len_in,
                                       logic [ptsp_pkg::SLOT_W-1:0] slot_in);
    int len, slot, first, hole, top;
    len  = int'(len_in);
    slot = int'(slot_in);
    if (len >= ptsp_pkg::LENGTHS) begin
      // no such prefix length: answered at once, table untouched
      add_plan(ptsp_pkg::KIND_MISSING, 0, 0, 1'b1);
      n_missing++;
      return;
    end
    if (cmd == ptsp_pkg::CMD_INSERT) begin
      n_inserts++;
      if (route_total >= TABLE_SLOTS) begin
        add_plan(ptsp_pkg::KIND_FULL, 0, 0, 1'b1);
        n_full++;
        return;
      end
      // each non-empty shorter group shifts up by one: its bottom entry jumps
      // over the group into the slot just past its top; empty ones are skipped
      for (int m = 0; m < len; m++) begin
        if (route_cnt[m] != 0) begin
          first = group_first(m);
          add_plan(ptsp_pkg::KIND_MOVE, first, first + route_cnt[m], 1'b0);
        end
      end
      add_plan(ptsp_pkg::KIND_PLACE, 0, group_first(len) + route_cnt[len], 1'b1);
      route_cnt[len]++;
      route_total++;
      if (route_total > peak_total) peak_total = route_total;
      return;
    end
    n_removes++;
    first = group_first(len);
    if (route_cnt[len] == 0 || slot < first || slot >= first + route_cnt[len]) begin
      add_plan(ptsp_pkg::KIND_MISSING, 0, 0, 1'b1);
      n_missing++;
      return;
    end
    // the hole bubbles down: each group's top entry drops into it, unless the
    // top already is the hole
    hole = slot;
    for (int m = len; m >= 0; m--) begin
      if (route_cnt[m] != 0) begin
        top = group_first(m) + route_cnt[m] - 1;
        if (top != hole) begin
          add_plan(ptsp_pkg::KIND_MOVE, top, hole, 1'b0);
          hole = top;
        end
      end
    end
    add_plan(ptsp_pkg::KIND_FREE, 0, route_total - 1, 1'b1);
    route_cnt[len]--;
    route_total--;
  endfunction

  // --------------------------------------------------------------------------
  // Command side: inputs change on the falling edge
  // --------------------------------------------------------------------------

  task automatic send_cmd(input logic cmd, input logic [ptsp_pkg::LEN_W-1:0] len,
                          input logic [ptsp_pkg::SLOT_W-1:0] slot);
    // random gaps, with junk on the fields while valid is low
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_ch.valid         = 1'b0;
      in_ch.command       = 1'($urandom_range(0, 1));
      in_ch.prefix_length = ptsp_pkg::LEN_W'($urandom);
      in_ch.slot_index    = ptsp_pkg::SLOT_W'($urandom);
      @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.command       = cmd;
    in_ch.prefix_length = len;
    in_ch.slot_index    = slot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    plan_command(cmd, len, slot);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // remove of a route that exists, drawn uniformly over the occupied slots
  task automatic remove_some_route();
    int s;
    s = int'($urandom_range(0, route_total - 1));
    send_cmd(ptsp_pkg::CMD_REMOVE, ptsp_pkg::LEN_W'(length_of_slot(s)),
             ptsp_pkg::SLOT_W'(s));
  endtask

  task automatic wait_drain();
    while (planned_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_idling(int snd, int rcv);
    snd_idle_pct  = snd;
    rcv_stall_pct = rcv;
  endtask

  // --------------------------------------------------------------------------
  // Result side: ready changes on the falling edge, items checked on the rising
  // --------------------------------------------------------------------------

  initial begin : result_sink
    int hold_left;
    int seen_req;
    hold_left    = 0;
    seen_req     = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (seen_req != long_hold_req) begin
        seen_req  = long_hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= rcv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    plan_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (planned_q.size() == 0) begin
        err_cnt++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: unexpected result kind %0d src %0d dst %0d last %0d", $time,
                   out_ch.result_kind, out_ch.source_slot, out_ch.target_slot,
                   out_ch.last_result);
        end
      end else begin
        want = planned_q.pop_front();
        if (out_ch.result_kind !== want.kind || out_ch.source_slot !== want.src ||
            out_ch.target_slot !== want.dst || out_ch.last_result !== want.last) begin
          err_cnt++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: result mismatch, expected kind %0d src %0d dst %0d last %0d",
                     $time, want.kind, want.src, want.dst, want.last);
            $display("%0t:                    actual kind %0d src %0d dst %0d last %0d",
                     $time, out_ch.result_kind, out_ch.source_slot, out_ch.target_slot,
                     out_ch.last_result);
          end
        end
      end
    end
  end

  // nothing moving on either channel for too long means the block is stuck
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("prefix_ordered_tcam_slot_planner_core test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // hand-picked commands: boundaries of the fields and each corner of the walk
  task automatic test_directed();
    int s;
    set_idling(0, 0);
    send_cmd(ptsp_pkg::CMD_REMOVE, 6'd0, 12'd0);       // empty table, empty group
    send_cmd(ptsp_pkg::CMD_INSERT, 6'd0, 12'hfff);     // first route, length 0 was empty
    send_cmd(ptsp_pkg::CMD_INSERT, 6'd32, 12'd0);      // length 0 group shifts up
    send_cmd(ptsp_pkg::CMD_INSERT, 6'd16, 12'd0);
    send_cmd(ptsp_pkg::CMD_INSERT, 6'd0, 12'd0);
    send_cmd(ptsp_pkg::CMD_INSERT, 6'd16, 12'd0);
    send_cmd(ptsp_pkg::CMD_INSERT, 6'd33, 12'hfff);    // lengths past 32 are never found
    send_cmd(ptsp_pkg::CMD_INSERT, 6'd63, 12'd0);
    send_cmd(ptsp_pkg::CMD_REMOVE, 6'd63, 12'hfff);
    send_cmd(ptsp_pkg::CMD_REMOVE, 6'd8, 12'd0);       // group empty
    send_cmd(ptsp_pkg::CMD_REMOVE, 6'd16, 12'd0);      // slot below the group
    send_cmd(ptsp_pkg::CMD_REMOVE, 6'd16, 12'hfff);    // slot above the group
    // removing the top of its own group: no move for that group
    send_cmd(ptsp_pkg::CMD_REMOVE, 6'd16,
             ptsp_pkg::SLOT_W'(group_first(16) + route_cnt[16] - 1));
    // removing the last slot of the table: no moves at all
    s = route_total - 1;
    send_cmd(ptsp_pkg::CMD_REMOVE, ptsp_pkg::LEN_W'(length_of_slot(s)),
             ptsp_pkg::SLOT_W'(s));
    send_cmd(ptsp_pkg::CMD_INSERT, 6'd1, 12'd0);
    send_cmd(ptsp_pkg::CMD_INSERT, 6'd7, 12'd0);
    send_cmd(ptsp_pkg::CMD_INSERT, 6'd24, 12'd0);
    send_cmd(ptsp_pkg::CMD_INSERT, 6'd31, 12'd0);
    send_cmd(ptsp_pkg::CMD_INSERT, 6'd32, 12'd0);      // every non-empty shorter group moves
    send_cmd(ptsp_pkg::CMD_REMOVE, 6'd32, 12'd0);      // hole travels through every non-empty group
    s = route_total - 1;
    send_cmd(ptsp_pkg::CMD_REMOVE, ptsp_pkg::LEN_W'(length_of_slot(s)),
             ptsp_pkg::SLOT_W'(s));
    wait_drain();
  endtask

  // mostly legal traffic that keeps a few dozen to a few hundred routes
  // live, with some bad lengths and stale removes mixed in
  task automatic test_random(int items, int snd, int rcv);
    int r, ins_pct;
    set_idling(snd, rcv);
    repeat (items) begin
      r = int'($urandom_range(0, 99));
      if (r < 8) begin
        send_cmd(1'($urandom_range(0, 1)), ptsp_pkg::LEN_W'($urandom_range(33, 63)),
                 ptsp_pkg::SLOT_W'($urandom));
      end else if (r < 15) begin
        send_cmd(ptsp_pkg::CMD_REMOVE, ptsp_pkg::LEN_W'($urandom_range(0, 32)),
                 ptsp_pkg::SLOT_W'($urandom));
      end else begin
        ins_pct = (route_total < 8) ? 85 : (route_total > 160) ? 35 : 58;
        if (route_total == 0 || $urandom_range(0, 99) < ins_pct)
          send_cmd(ptsp_pkg::CMD_INSERT, ptsp_pkg::LEN_W'($urandom_range(0, 32)),
                   ptsp_pkg::SLOT_W'($urandom));
        else
          remove_some_route();
      end
    end
    wait_drain();
  endtask

  // receiver holds off for a long stretch while commands keep coming, so
  // the output register and then the command port back up
  task automatic test_backpressure();
    set_idling(0, 33);
    @(posedge clk);
    long_hold_req++;
    @(negedge clk);
    repeat (12) begin
      if (route_total == 0 || $urandom_range(0, 1) == 0)
        send_cmd(ptsp_pkg::CMD_INSERT, ptsp_pkg::LEN_W'($urandom_range(0, 32)),
                 ptsp_pkg::SLOT_W'($urandom));
      else
        remove_some_route();
    end
    // sender goes quiet until every owed item is out
    wait_drain();
    set_idling(33, 33);
    repeat (8)
      send_cmd(ptsp_pkg::CMD_INSERT, ptsp_pkg::LEN_W'($urandom_range(0, 32)),
               ptsp_pkg::SLOT_W'($urandom));
    wait_drain();
  endtask

  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.command       = ptsp_pkg::CMD_INSERT;
    in_ch.prefix_length = '0;
    in_ch.slot_index    = '0;
    foreach (route_cnt[i]) route_cnt[i] = 0;
    route_total     = 0;
    peak_total      = 0;
    snd_idle_pct    = 0;
    rcv_stall_pct   = 0;
    long_hold_req   = 0;
    err_cnt         = 0;
    reports         = 0;
    results_checked = 0;
    n_inserts       = 0;
    n_removes       = 0;
    n_missing       = 0;
    n_full          = 0;
    moves_planned   = 0;

    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random(65, 0, 0);
    test_random(65, 46, 0);
    test_random(65, 0, 46);
    test_random(65, 33, 33);
    test_backpressure();

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run: %0d inserts, %0d removes, %0d not found, %0d table full answers.",
             n_inserts, n_removes, n_missing, n_full);
    $display("     %0d moves planned, %0d result items checked, table peaked at %0d routes.",
             moves_planned, results_checked, peak_total);
    if (err_cnt == 0 && planned_q.size() == 0) begin
      $display("prefix_ordered_tcam_slot_planner_core test passed");
    end else begin
      $display("%0d mismatches, %0d results still owed", err_cnt, planned_q.size());
      $display("prefix_ordered_tcam_slot_planner_core test failed");
    end
    $finish;
  end

endmodule
